[sv/tgti_pkg.sv]
// ----------------------------------------------------------------------------
// tgti_pkg
// Shared types and constants for the terrain grid triangle interpolator.
// ----------------------------------------------------------------------------
package tgti_pkg;

  // field widths
  localparam int SIDE_W   = 11;
  localparam int FIELD_W  = 20;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = FIELD_W + SIDE_W;

  // parameter defaults
  localparam int DEF_MAX_GRID_SIDE = 1024;
  localparam int DEF_FRAC_BITS     = 20;

  // grid side register
  localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 11'd2;

  // queue depths
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 8;

  // no-data codes and their replacement
  localparam logic signed [SAMPLE_W-1:0] NODATA_VOID = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] NODATA_SEA  = -16'sd500;
  localparam logic signed [SAMPLE_W-1:0] NODATA_FILL = -16'sd1;

  // saturation limits of the result
  localparam logic signed [SAMPLE_W-1:0] ALT_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] ALT_MIN = 16'sh8000;

  // item kinds
  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                is_query;
    logic [SIDE_W-1:0]   col;
    logic [SIDE_W-1:0]   row;
    logic                edge_x;
    logic                edge_y;
    logic                upper;
    logic [FIELD_W-1:0]  load_index;
    logic [SAMPLE_W-1:0] load_value;
  } q_hdr_t;

endpackage

[sv/tgti_fifo.sv]
// ----------------------------------------------------------------------------
// tgti_fifo
// Small register queue with valid/ready on both sides and an occupancy count.
// ----------------------------------------------------------------------------
module tgti_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [WIDTH-1:0]           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [WIDTH-1:0]           out_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic             push;
  logic             pop;

  // handshake
  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_data;
    end
  end

endmodule

[sv/tgti_front.sv]
// ----------------------------------------------------------------------------
// tgti_front
// Accepts items, scales query fractions by the grid side and classifies them
// into cell, in-cell fraction, edge and triangle before queueing.
// ----------------------------------------------------------------------------
module tgti_front #(
  parameter int MAX_GRID_SIDE = tgti_pkg::DEF_MAX_GRID_SIDE,
  parameter int FRAC_BITS     = tgti_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tgti_pkg::SIDE_W-1:0]  side,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [tgti_pkg::FIELD_W-1:0] sample_index,
  input  logic signed [tgti_pkg::SAMPLE_W-1:0] sample_value,
  input  logic [tgti_pkg::FIELD_W-1:0] lon_frac,
  input  logic [tgti_pkg::FIELD_W-1:0] lat_frac,
  output logic                         q_valid,
  input  logic                         q_ready,
  output tgti_pkg::q_hdr_t             q_hdr,
  output logic [FRAC_BITS-1:0]         q_fx,
  output logic [FRAC_BITS-1:0]         q_fy
);

  import tgti_pkg::*;

  localparam longint unsigned STORE_DEPTH = longint'(MAX_GRID_SIDE) * longint'(MAX_GRID_SIDE);

  logic                fv;
  logic                f_query;
  logic [FIELD_W-1:0]  f_index;
  logic [SAMPLE_W-1:0] f_value;
  logic [PROD_W-1:0]   f_cx;
  logic [PROD_W-1:0]   f_cy;

  logic                in_xfer;
  logic                is_query;
  logic                load_ok;
  logic [SIDE_W-1:0]   side_m1;
  logic [PROD_W-1:0]   col_raw;
  logic [PROD_W-1:0]   row_raw;
  logic [SIDE_W-1:0]   col;
  logic [SIDE_W-1:0]   row;

  // intake
  assign in_ready = !fv || q_ready;
  assign in_xfer  = in_valid && in_ready;
  assign is_query = (mode == MODE_QUERY);
  assign load_ok  = (64'(sample_index) < STORE_DEPTH);

  // loads outside the store are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_ready) begin
      fv <= in_valid && (is_query || load_ok);
    end
  end

  // scale fractions by the grid side
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      f_query <= is_query;
      f_index <= sample_index;
      f_value <= sample_value;
      f_cx    <= PROD_W'(lon_frac) * PROD_W'(side);
      f_cy    <= PROD_W'(lat_frac) * PROD_W'(side);
    end
  end

  // cell index, clamped to the last cell
  assign side_m1 = side - 1'b1;
  assign col_raw = f_cx >> FRAC_BITS;
  assign row_raw = f_cy >> FRAC_BITS;
  assign col     = (col_raw > PROD_W'(side_m1)) ? side_m1 : col_raw[SIDE_W-1:0];
  assign row     = (row_raw > PROD_W'(side_m1)) ? side_m1 : row_raw[SIDE_W-1:0];

  // classified item
  assign q_valid = fv;
  assign q_fx    = f_cx[FRAC_BITS-1:0];
  assign q_fy    = f_cy[FRAC_BITS-1:0];

  always_comb begin
    q_hdr            = '0;
    q_hdr.is_query   = f_query;
    q_hdr.col        = col;
    q_hdr.row        = row;
    q_hdr.edge_x     = (col == side_m1);
    q_hdr.edge_y     = (row == side_m1);
    q_hdr.upper      = (q_fx > q_fy);
    q_hdr.load_index = f_index;
    q_hdr.load_value = f_value;
  end

endmodule

[sv/tgti_back.sv]
// ----------------------------------------------------------------------------
// tgti_back
// Executes classified items: writes loads into the banked elevation store,
// reads four corners per query, interpolates and queues the result.
// ----------------------------------------------------------------------------
module tgti_back #(
  parameter int MAX_GRID_SIDE = tgti_pkg::DEF_MAX_GRID_SIDE,
  parameter int FRAC_BITS     = tgti_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tgti_pkg::SIDE_W-1:0]   side,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  tgti_pkg::q_hdr_t              q_hdr,
  input  logic [FRAC_BITS-1:0]          q_fx,
  input  logic [FRAC_BITS-1:0]          q_fy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tgti_pkg::SAMPLE_W-1:0] altitude
);

  import tgti_pkg::*;

  localparam int AW         = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE);
  localparam int BANK_AW    = AW - 1;
  localparam int BANK_DEPTH = 2 ** BANK_AW;
  localparam int BASE_W     = 2 * SIDE_W;
  localparam int LIN_W      = BASE_W + 1;
  localparam int PRD_W      = FRAC_BITS + SAMPLE_W + 2;
  localparam int SUM_W      = FRAC_BITS + SAMPLE_W + 4;
  localparam int QT_W       = SUM_W - FRAC_BITS;
  localparam int CRW        = $clog2(OUT_DEPTH + 1);

  function automatic logic signed [SAMPLE_W-1:0] nodata_map(
    input logic signed [SAMPLE_W-1:0] v
  );
    if (v == NODATA_VOID || v == NODATA_SEA) begin
      return NODATA_FILL;
    end
    return v;
  endfunction

  // credit and issue
  logic [CRW-1:0] credit;
  logic           issue;
  logic           out_xfer;
  logic [CRW-1:0] o_count;
  logic           o_in_ready;

  // stage 1: row base
  logic                v1;
  logic                q1;
  logic [BASE_W-1:0]   base1;
  logic [SIDE_W-1:0]   col1;
  logic [SIDE_W-1:0]   colp1;
  logic                ex1;
  logic                ey1;
  logic                up1;
  logic [FRAC_BITS-1:0] fx1;
  logic [FRAC_BITS-1:0] fy1;
  logic [FIELD_W-1:0]  widx1;
  logic [SAMPLE_W-1:0] wval1;

  // store access
  logic [LIN_W-1:0]    p_lin;
  logic [LIN_W-1:0]    pn_lin;
  logic [LIN_W-1:0]    b_lin;
  logic [LIN_W-1:0]    bn_lin;
  logic [BANK_AW-1:0]  idx_e0;
  logic [BANK_AW-1:0]  idx_o0;
  logic [BANK_AW-1:0]  idx_e1;
  logic [BANK_AW-1:0]  idx_o1;
  logic                we;
  logic [BANK_AW-1:0]  waddr;
  logic [SAMPLE_W-1:0] bank_even [BANK_DEPTH];
  logic [SAMPLE_W-1:0] bank_odd  [BANK_DEPTH];

  // stage 2: corner data
  logic                       v2;
  logic                       sw0;
  logic                       sw1;
  logic                       ex2;
  logic                       ey2;
  logic                       up2;
  logic [FRAC_BITS-1:0]       fx2;
  logic [FRAC_BITS-1:0]       fy2;
  logic signed [SAMPLE_W-1:0] rd_e0;
  logic signed [SAMPLE_W-1:0] rd_o0;
  logic signed [SAMPLE_W-1:0] rd_e1;
  logic signed [SAMPLE_W-1:0] rd_o1;
  logic signed [SAMPLE_W-1:0] m_e0;
  logic signed [SAMPLE_W-1:0] m_o0;
  logic signed [SAMPLE_W-1:0] m_e1;
  logic signed [SAMPLE_W-1:0] m_o1;
  logic signed [SAMPLE_W-1:0] a1;
  logic signed [SAMPLE_W-1:0] a2;
  logic signed [SAMPLE_W-1:0] a3;
  logic signed [SAMPLE_W-1:0] a4;
  logic signed [SAMPLE_W:0]   dx_c;
  logic signed [SAMPLE_W:0]   dy_c;

  // stage 3: slopes
  logic                       v3;
  logic signed [SAMPLE_W-1:0] a1_3;
  logic signed [SAMPLE_W:0]   dx3;
  logic signed [SAMPLE_W:0]   dy3;
  logic [FRAC_BITS-1:0]       fx3;
  logic [FRAC_BITS-1:0]       fy3;

  // stage 4: products
  logic                       v4;
  logic signed [SAMPLE_W-1:0] a1_4;
  logic signed [PRD_W-1:0]    px4;
  logic signed [PRD_W-1:0]    py4;
  logic signed [SUM_W-1:0]    sum4;
  logic signed [QT_W-1:0]     quot;
  logic                       rnd;
  logic signed [QT_W-1:0]     qt;
  logic signed [SAMPLE_W-1:0] alt4;

  // a query issues only with room reserved in the result queue
  assign q_ready  = !q_hdr.is_query || (credit < CRW'(OUT_DEPTH));
  assign issue    = q_valid && q_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CRW'(issue && q_hdr.is_query) - CRW'(out_xfer);
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1 && q1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: row base address
  always_ff @(posedge clk) begin
    q1    <= q_hdr.is_query;
    base1 <= BASE_W'(q_hdr.row) * BASE_W'(side);
    col1  <= q_hdr.col;
    colp1 <= q_hdr.col + 1'b1;
    ex1   <= q_hdr.edge_x;
    ey1   <= q_hdr.edge_y;
    up1   <= q_hdr.upper;
    fx1   <= q_fx;
    fy1   <= q_fy;
    widx1 <= q_hdr.load_index;
    wval1 <= q_hdr.load_value;
  end

  // corner addresses, split into even and odd banks
  assign p_lin  = LIN_W'(base1) + LIN_W'(col1);
  assign pn_lin = LIN_W'(base1) + LIN_W'(colp1);
  assign b_lin  = p_lin + LIN_W'(side);
  assign bn_lin = pn_lin + LIN_W'(side);
  assign idx_e0 = BANK_AW'(pn_lin >> 1);
  assign idx_o0 = BANK_AW'(p_lin >> 1);
  assign idx_e1 = BANK_AW'(bn_lin >> 1);
  assign idx_o1 = BANK_AW'(b_lin >> 1);
  assign we     = v1 && !q1;
  assign waddr  = BANK_AW'(widx1 >> 1);

  // even bank: one write, two reads
  always_ff @(posedge clk) begin
    if (we && !widx1[0]) begin
      bank_even[waddr] <= wval1;
    end
    rd_e0 <= bank_even[idx_e0];
    rd_e1 <= bank_even[idx_e1];
  end

  // odd bank: one write, two reads
  always_ff @(posedge clk) begin
    if (we && widx1[0]) begin
      bank_odd[waddr] <= wval1;
    end
    rd_o0 <= bank_odd[idx_o0];
    rd_o1 <= bank_odd[idx_o1];
  end

  // stage 2 control alongside the read data
  always_ff @(posedge clk) begin
    sw0 <= p_lin[0];
    sw1 <= b_lin[0];
    ex2 <= ex1;
    ey2 <= ey1;
    up2 <= up1;
    fx2 <= fx1;
    fy2 <= fy1;
  end

  // no-data mapping, corner ordering and far-edge substitution
  assign m_e0 = nodata_map(rd_e0);
  assign m_o0 = nodata_map(rd_o0);
  assign m_e1 = nodata_map(rd_e1);
  assign m_o1 = nodata_map(rd_o1);
  assign a1   = sw0 ? m_o0 : m_e0;
  assign a2   = ex2 ? a1 : (sw0 ? m_e0 : m_o0);
  assign a3   = ey2 ? a1 : (sw1 ? m_o1 : m_e1);
  assign a4   = (ex2 || ey2) ? a1 : (sw1 ? m_e1 : m_o1);

  // triangle slopes
  always_comb begin
    if (up2) begin
      dx_c = $signed({a2[SAMPLE_W-1], a2}) - $signed({a1[SAMPLE_W-1], a1});
      dy_c = $signed({a4[SAMPLE_W-1], a4}) - $signed({a2[SAMPLE_W-1], a2});
    end else begin
      dx_c = $signed({a4[SAMPLE_W-1], a4}) - $signed({a3[SAMPLE_W-1], a3});
      dy_c = $signed({a3[SAMPLE_W-1], a3}) - $signed({a1[SAMPLE_W-1], a1});
    end
  end

  always_ff @(posedge clk) begin
    a1_3 <= a1;
    dx3  <= dx_c;
    dy3  <= dy_c;
    fx3  <= fx2;
    fy3  <= fy2;
  end

  // stage 4: slope times fraction
  always_ff @(posedge clk) begin
    a1_4 <= a1_3;
    px4  <= dx3 * $signed({1'b0, fx3});
    py4  <= dy3 * $signed({1'b0, fy3});
  end

  // sum, truncate toward zero, saturate
  assign sum4 = $signed({{(SUM_W - SAMPLE_W - FRAC_BITS){a1_4[SAMPLE_W-1]}},
                         a1_4, {FRAC_BITS{1'b0}}})
              + SUM_W'(px4) + SUM_W'(py4);
  assign quot = $signed(sum4[SUM_W-1:FRAC_BITS]);
  assign rnd  = sum4[SUM_W-1] && (sum4[FRAC_BITS-1:0] != '0);
  assign qt   = quot + $signed({{(QT_W - 1){1'b0}}, rnd});

  always_comb begin
    if (qt[QT_W-1:SAMPLE_W-1] == '0 || qt[QT_W-1:SAMPLE_W-1] == '1) begin
      alt4 = qt[SAMPLE_W-1:0];
    end else if (qt[QT_W-1]) begin
      alt4 = ALT_MIN;
    end else begin
      alt4 = ALT_MAX;
    end
  end

  // result queue
  tgti_fifo #(
    .WIDTH (SAMPLE_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (o_in_ready),
    .in_data   (alt4),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (altitude),
    .count     (o_count)
  );

  // credits never exceed the result queue
  a_credit_max: assert property (@(posedge clk) disable iff (rst)
    credit <= CRW'(OUT_DEPTH))
    else $error("credit count above result queue depth");

  // queued results are always covered by credits
  a_count_credit: assert property (@(posedge clk) disable iff (rst)
    o_count <= credit)
    else $error("result queue holds more than issued queries");

  // a finished result always finds room
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    v4 |-> o_in_ready)
    else $error("result dropped on full queue");

endmodule

[sv/terrain_grid_triangle_interp_top.sv]
// ----------------------------------------------------------------------------
// terrain_grid_triangle_interp_top
// Elevation tile store with triangular interpolation of query positions.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_ready is high: loads write one
// sample into the tile and give no result, queries give one altitude each, in
// order. A front stage scales and classifies, a four-entry queue decouples it
// from the back pipeline, which reads all four cell corners together from two
// store banks (even and odd address), each with one write port and two read
// ports, then multiplies and sums over two more stages into an eight-entry
// result queue. Queries issue only while a result slot is reserved, so a
// stalled output backs up through the queues to in_ready. Loads take effect
// before any later query reads. The store has no reset; a query that touches
// a never-written sample returns an undefined altitude. grid_side must be
// written only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module terrain_grid_triangle_interp_top #(
  parameter int MAX_GRID_SIDE = tgti_pkg::DEF_MAX_GRID_SIDE,
  parameter int FRAC_BITS     = tgti_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 mode,
  input  logic [tgti_pkg::FIELD_W-1:0]         sample_index,
  input  logic signed [tgti_pkg::SAMPLE_W-1:0] sample_value,
  input  logic [tgti_pkg::FIELD_W-1:0]         lon_frac,
  input  logic [tgti_pkg::FIELD_W-1:0]         lat_frac,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tgti_pkg::SAMPLE_W-1:0] altitude,
  input  logic                                 cfg_wr_en,
  input  logic [tgti_pkg::SIDE_W-1:0]          cfg_wr_data
);

  import tgti_pkg::*;

  localparam int QW = $bits(q_hdr_t) + 2 * FRAC_BITS;

  logic [SIDE_W-1:0]    grid_side;
  logic [SIDE_W-1:0]    side;

  logic                 fq_valid;
  logic                 fq_ready;
  q_hdr_t               f_hdr;
  logic [FRAC_BITS-1:0] f_fx;
  logic [FRAC_BITS-1:0] f_fy;

  logic                 bq_valid;
  logic                 bq_ready;
  logic [QW-1:0]        bq_data;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] iq_count;
  q_hdr_t               b_hdr;
  logic [FRAC_BITS-1:0] b_fx;
  logic [FRAC_BITS-1:0] b_fy;

  // grid side register
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= SIDE_RESET;
    end else if (cfg_wr_en) begin
      grid_side <= cfg_wr_data;
    end
  end

  // effective side, clamped to the supported range
  always_comb begin
    if (grid_side < SIDE_MIN) begin
      side = SIDE_MIN;
    end else if (32'(grid_side) > MAX_GRID_SIDE) begin
      side = SIDE_W'(MAX_GRID_SIDE);
    end else begin
      side = grid_side;
    end
  end

  // intake and classification
  tgti_front #(
    .MAX_GRID_SIDE (MAX_GRID_SIDE),
    .FRAC_BITS     (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .side         (side),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .lon_frac     (lon_frac),
    .lat_frac     (lat_frac),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_hdr        (f_hdr),
    .q_fx         (f_fx),
    .q_fy         (f_fy)
  );

  // decoupling queue
  tgti_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   ({f_hdr, f_fx, f_fy}),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data),
    .count     (iq_count)
  );

  assign {b_hdr, b_fx, b_fy} = bq_data;

  // store and interpolation
  tgti_back #(
    .MAX_GRID_SIDE (MAX_GRID_SIDE),
    .FRAC_BITS     (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .side      (side),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_hdr     (b_hdr),
    .q_fx      (b_fx),
    .q_fy      (b_fy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .altitude  (altitude)
  );

  // item queue never holds more than its depth
  a_iq_bound: assert property (@(posedge clk) disable iff (rst)
    32'(iq_count) <= QUEUE_DEPTH)
    else $error("item queue count above its depth");

  // effective side stays in the supported range
  a_side_range: assert property (@(posedge clk) disable iff (rst)
    (side >= SIDE_MIN) && (32'(side) <= MAX_GRID_SIDE))
    else $error("effective grid side out of range");

  // a waiting result holds steady until it transfers
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(altitude))
    else $error("result changed or dropped while waiting");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the terrain grid triangle interpolator.
// ----------------------------------------------------------------------------
// Loads go into a mirror of the elevation tile, and each accepted query is
// predicted on the spot from that mirror. Query positions always land on cells
// whose corners were written first. A checker compares every output transfer
// with the oldest pending altitude. The run goes through directed edge cases,
// a sweep of grid_side values (out of range ones too), idle/stall phases, and
// one long output hold-off that fills the block up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgti_pkg::*;

  localparam int MAX_SIDE     = DEF_MAX_GRID_SIDE;
  localparam int FRAC         = DEF_FRAC_BITS;
  localparam int STORE_DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SHOW_ERRORS  = 10;

  typedef struct {
    int unsigned row;
    int unsigned col;
  } cell_t;

  // block ports
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       mode = MODE_LOAD;
  logic [FIELD_W-1:0]         sample_index = '0;
  logic signed [SAMPLE_W-1:0] sample_value = '0;
  logic [FIELD_W-1:0]         lon_frac = '0;
  logic [FIELD_W-1:0]         lat_frac = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] altitude;
  logic                       cfg_wr_en = 1'b0;
  logic [SIDE_W-1:0]          cfg_wr_data = '0;

  // mirror of the tile and the grid side register
  bit signed [SAMPLE_W-1:0] tile_mem [STORE_DEPTH];
  bit                       tile_written [STORE_DEPTH];
  logic [SIDE_W-1:0]        side_reg = SIDE_RESET;

  logic signed [SAMPLE_W-1:0] alt_expected [$];
  cell_t                      ready_cells [$];

  // traffic shaping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  // run statistics
  int          error_count     = 0;
  int          results_checked = 0;
  int          load_count      = 0;
  int          query_count     = 0;
  int          items_sent      = 0;
  int          side_writes     = 0;
  int          in_stall_cycles = 0;
  int unsigned cycle_count     = 0;

  terrain_grid_triangle_interp_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .lon_frac     (lon_frac),
    .lat_frac     (lat_frac),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .altitude     (altitude),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_side();
    if (side_reg < SIDE_MIN) return int'(SIDE_MIN);
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return int'(side_reg);
  endfunction

  function automatic int unsigned cell_addr(input int unsigned row, input int unsigned col);
    return row * eff_side() + col;
  endfunction

  // cell index, in-cell fraction and far-edge flags of a position
  function automatic void locate(input logic [FIELD_W-1:0] lon, input logic [FIELD_W-1:0] lat,
                                 output int unsigned row, output int unsigned col,
                                 output longint fx, output longint fy,
                                 output bit ex, output bit ey);
    longint unsigned s, cx, cy, fmask;
    s = eff_side();
    fmask = (longint'(1) << FRAC) - 1;
    cx = longint'(lon) * s;
    cy = longint'(lat) * s;
    col = int'(cx >> FRAC);
    row = int'(cy >> FRAC);
    if (col > s - 1) col = int'(s - 1);
    if (row > s - 1) row = int'(s - 1);
    fx = longint'(cx & fmask);
    fy = longint'(cy & fmask);
    ex = (col + 1) >= s;
    ey = (row + 1) >= s;
  endfunction

  // stored sample with the no-data codes folded to the fill value
  function automatic longint corner_value(input int unsigned row, input int unsigned col);
    logic signed [SAMPLE_W-1:0] raw;
    raw = tile_mem[cell_addr(row, col)];
    if (raw == NODATA_VOID || raw == NODATA_SEA) return NODATA_FILL;
    return raw;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] interp_altitude(
      input logic [FIELD_W-1:0] lon, input logic [FIELD_W-1:0] lat);
    int unsigned row, col;
    longint      fx, fy, a1, a2, a3, a4, one, acc, q;
    bit          ex, ey;
    locate(lon, lat, row, col, fx, fy, ex, ey);
    a1 = corner_value(row, col);
    a2 = ex ? a1 : corner_value(row, col + 1);
    a3 = ey ? a1 : corner_value(row + 1, col);
    a4 = (ex || ey) ? a1 : corner_value(row + 1, col + 1);
    one = longint'(1) << FRAC;
    // upper triangle when strictly right of the diagonal, lower otherwise
    if (fx > fy) acc = a1 * one + (a2 - a1) * fx + (a4 - a2) * fy;
    else         acc = a1 * one + (a4 - a3) * fx + (a3 - a1) * fy;
    q = acc / one;
    if (q > ALT_MAX) q = ALT_MAX;
    if (q < ALT_MIN) q = ALT_MIN;
    return q[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic bit corners_written(input int unsigned row, input int unsigned col,
                                         input bit ex, input bit ey);
    if (!tile_written[cell_addr(row, col)]) return 1'b0;
    if (!ex && !tile_written[cell_addr(row, col + 1)]) return 1'b0;
    if (!ey && !tile_written[cell_addr(row + 1, col)]) return 1'b0;
    if (!ex && !ey && !tile_written[cell_addr(row + 1, col + 1)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return NODATA_VOID;
    if (pick < 20) return NODATA_SEA;
    if (pick < 25) return ALT_MAX;
    if (pick < 30) return -16'sd32767;
    if (pick < 50) return SAMPLE_W'(int'($urandom_range(200)) - 100);
    return SAMPLE_W'($urandom);
  endfunction

  // random fraction that scales into the given cell index
  function automatic logic [FIELD_W-1:0] frac_in_cell(input int unsigned idx);
    longint unsigned s, lo, hi;
    int unsigned     pick;
    s = eff_side();
    lo = ((longint'(idx) << FRAC) + s - 1) / s;
    hi = ((longint'(idx + 1) << FRAC) + s - 1) / s - 1;
    pick = $urandom_range(9);
    if (pick == 0) return lo[FIELD_W-1:0];
    if (pick == 1) return hi[FIELD_W-1:0];
    return FIELD_W'(lo + $urandom_range(32'(hi - lo)));
  endfunction

  // one input transfer; the mirror is updated when it is accepted
  task automatic send_item(input mode_t kind, input logic [FIELD_W-1:0] index,
                           input logic signed [SAMPLE_W-1:0] value,
                           input logic [FIELD_W-1:0] lon, input logic [FIELD_W-1:0] lat);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= kind;
    sample_index <= index;
    sample_value <= value;
    lon_frac     <= lon;
    lat_frac     <= lat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == MODE_LOAD) begin
      tile_mem[index]     = value;
      tile_written[index] = 1'b1;
      load_count++;
    end else begin
      alt_expected.insert(alt_expected.size(), interp_altitude(lon, lat));
      query_count++;
    end
    items_sent++;
  endtask

  task automatic send_load(input logic [FIELD_W-1:0] index,
                           input logic signed [SAMPLE_W-1:0] value);
    send_item(MODE_LOAD, index, value, FIELD_W'($urandom), FIELD_W'($urandom));
  endtask

  task automatic send_query(input logic [FIELD_W-1:0] lon, input logic [FIELD_W-1:0] lat);
    send_item(MODE_QUERY, FIELD_W'($urandom), SAMPLE_W'($urandom), lon, lat);
  endtask

  // write every corner that a query in this cell reads
  task automatic load_cell(input int unsigned row, input int unsigned col);
    bit    ex, ey;
    cell_t c;
    ex = (col + 1) >= eff_side();
    ey = (row + 1) >= eff_side();
    send_load(FIELD_W'(cell_addr(row, col)), random_sample());
    if (!ex) send_load(FIELD_W'(cell_addr(row, col + 1)), random_sample());
    if (!ey) send_load(FIELD_W'(cell_addr(row + 1, col)), random_sample());
    if (!ex && !ey) send_load(FIELD_W'(cell_addr(row + 1, col + 1)), random_sample());
    c.row = row;
    c.col = col;
    ready_cells.insert(ready_cells.size(), c);
  endtask

  // stop offering, let pending results drain, then give the back end time to settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (alt_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid_side(input logic [SIDE_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    side_reg = value;
    ready_cells.delete();
    side_writes++;
  endtask

  // mixed loads and queries; every query first gets its cell corners written
  task automatic run_traffic(input int n_items, input int query_pct);
    int          stop_at, pick;
    int unsigned row, col, dr, dc;
    longint      fx, fy;
    bit          ex, ey;
    cell_t       c;
    logic [FIELD_W-1:0] lon, lat;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < query_pct && ready_cells.size() != 0) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          c   = ready_cells[$urandom_range(ready_cells.size() - 1)];
          lon = frac_in_cell(c.col);
          lat = frac_in_cell(c.row);
        end else if (pick < 80) begin
          // on the diagonal
          lon = FIELD_W'($urandom);
          lat = lon;
        end else if (pick < 90) begin
          lon = $urandom_range(1) ? '1 : '0;
          lat = $urandom_range(1) ? '1 : '0;
        end else begin
          lon = FIELD_W'($urandom);
          lat = FIELD_W'($urandom);
        end
        locate(lon, lat, row, col, fx, fy, ex, ey);
        if (!corners_written(row, col, ex, ey)) load_cell(row, col);
        send_query(lon, lat);
      end else begin
        pick = $urandom_range(99);
        if (pick < 40 || ready_cells.size() == 0) begin
          // new cell, biased toward the far edges
          col = ($urandom_range(4) == 0) ? eff_side() - 1 : $urandom_range(eff_side() - 1);
          row = ($urandom_range(4) == 0) ? eff_side() - 1 : $urandom_range(eff_side() - 1);
          load_cell(row, col);
        end else if (pick < 80) begin
          // rewrite one corner of a cell that queries use
          c  = ready_cells[$urandom_range(ready_cells.size() - 1)];
          dc = (c.col + 1 >= eff_side()) ? 0 : $urandom_range(1);
          dr = (c.row + 1 >= eff_side()) ? 0 : $urandom_range(1);
          send_load(FIELD_W'(cell_addr(c.row + dr, c.col + dc)), random_sample());
        end else begin
          send_load(FIELD_W'($urandom), random_sample());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset grid side, extremes of position and sample, no-data codes,
  // far-edge cells, both triangles, the diagonal, load followed by query
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_load(20'd0, ALT_MAX);
    send_load(20'd1, NODATA_VOID);
    send_load(20'd1024, NODATA_SEA);
    send_load(20'd1025, -16'sd32767);
    send_load(20'hFFFFF, 16'sd12345);
    send_load(20'd1023, -16'sd2000);
    send_load(20'd2047, 16'sd3000);
    send_load(20'd1047552, 16'sd500);
    send_load(20'd1047553, -16'sd700);
    send_query(20'd0, 20'd0);
    send_query(20'h003FF, 20'd0);
    send_query(20'd0, 20'h003FF);
    send_query(20'h003FF, 20'h003FF);
    send_query(20'h00200, 20'h00100);
    send_query(20'hFFFFF, 20'd0);
    send_query(20'd0, 20'hFFFFF);
    send_query(20'hFFFFF, 20'hFFFFF);
    send_load(20'd0, NODATA_SEA);
    send_query(20'd0, 20'd0);
    send_load(20'hFFFFF, NODATA_VOID);
    send_query(20'hFFFFF, 20'hFFFFF);
  endtask

  // register values inside and outside the legal range
  task automatic test_grid_side_settings();
    logic [SIDE_W-1:0] sides [6];
    sides = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd2047, 11'd1000};
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    foreach (sides[i]) begin
      set_grid_side(sides[i]);
      run_traffic(50, 60);
    end
  endtask

  // idle and stall phases on both sides of the block
  task automatic test_idle_phases();
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 65, 0, 15};
    recv_pct = '{0, 0, 65, 15};
    foreach (send_pct[i]) begin
      set_grid_side((i == 0) ? SIDE_RESET : SIDE_W'($urandom_range(2, MAX_SIDE)));
      send_idle_pct  = send_pct[i];
      recv_stall_pct = recv_pct[i];
      run_traffic(300, 60);
    end
  endtask

  // long output hold-off while queries keep coming
  task automatic test_output_backpressure();
    set_grid_side(SIDE_W'($urandom_range(2, MAX_SIDE)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_traffic(20, 0);
    hold_request = 300;
    run_traffic(120, 90);
  endtask

  // ---------------------------------------------------------------- processes

  // output ready: random stalls, or a counted hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each result transfer with the oldest pending altitude
  always @(posedge clk) begin : result_check
    logic signed [SAMPLE_W-1:0] want;
    if (!rst && in_valid && !in_ready) in_stall_cycles++;
    if (!rst && out_valid && out_ready) begin
      if (alt_expected.size() == 0) begin
        if (error_count < SHOW_ERRORS)
          $display("unexpected result at %0t: altitude %0d", $realtime, altitude);
        error_count++;
      end else begin
        want = alt_expected.pop_front();
        results_checked++;
        if (altitude !== want) begin
          if (error_count < SHOW_ERRORS)
            $display("altitude mismatch at %0t: expected %0d, got %0d",
                     $realtime, want, altitude);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               alt_expected.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_grid_side_settings();
    test_idle_phases();
    test_output_backpressure();
    wait_idle();

    if (alt_expected.size() != 0) error_count += alt_expected.size();
    $display("covered %0d loads and %0d queries over %0d grid_side writes, %0d results checked",
             load_count, query_count, side_writes, results_checked);
    $display("input held off for %0d cycles in total, %0d errors",
             in_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/tgti_pkg.sv
sv/tgti_fifo.sv
sv/tgti_front.sv
sv/tgti_back.sv
sv/terrain_grid_triangle_interp_top.sv
sim/tb.sv
